### rtl/stereo_feedback_delay_core_defines.svh
// Assertion macros for the stereo feedback delay core.
`ifndef STEREO_FEEDBACK_DELAY_CORE_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfd_pkg.sv
// Shared types, constants and helpers of the stereo feedback delay core.
package sfd_pkg;

    localparam int DEFAULT_STORE_DEPTH = 32768;
    localparam int CFG_DATA_W          = 15;
    localparam int CFG_INDEX_W         = 2;

    // Gain cap: 0.98 in unsigned Q0.15
    localparam logic [14:0] GAIN_CAP = 15'd32112;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PING_MODE     = 2'd2;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } sfd_in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } sfd_out_t;

    // Saturate an 18-bit sum to signed 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] res;
        if (v > 18'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Sample plus scaled feedback term, both sign-extended to 18 bits.
    function automatic logic signed [15:0] mix(input logic signed [15:0] smp,
                                               input logic signed [16:0] fb);
        logic signed [17:0] sum;
        sum = {{2{smp[15]}}, smp} + {fb[16], fb};
        return sat16(sum);
    endfunction

endpackage

### rtl/stereo_feedback_delay_core.sv
// Top level of the stereo feedback delay core: delay store, feedback mix, output register.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one stereo Q1.15 pair per beat.
//   Result channel m_valid/m_ready/m_data carries one saturated pair per beat.
//   Config port cfg_wr_en/cfg_index/cfg_wdata writes delay_length (0),
//   feedback_gain (1) and ping_mode (2); write only while the block is idle.
// Path: an accepted beat passes the mix stage register, then the output register, to m_data.
// Throughput: one beat per cycle while m_ready stays high. Each beat does one read
//   of the shared left/right store and one write back; a delay of one sample is
//   served by forwarding the pair being written in the same cycle.
// Reset: aresetn (sync, low) resets the write pointer, the config registers
//   and the pipeline. The store itself is not swept: until the write pointer
//   first wraps, entries at or above it read as zero, so no clearing pass is
//   needed and beats are taken right after reset.
// Stall: two slots (compute stage plus output register) absorb back-pressure;
//   s_ready drops only when both are full and m_ready is low.
`include "stereo_feedback_delay_core_defines.svh"

module stereo_feedback_delay_core #(
    parameter int STORE_DEPTH = sfd_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sfd_pkg::sfd_in_t                    s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output sfd_pkg::sfd_out_t                   m_data,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import sfd_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    // wide enough for w + STORE_DEPTH and for the raw 15-bit delay
    localparam int XW = ((AW > CFG_DATA_W) ? AW : CFG_DATA_W) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam logic [XW-1:0] DEPTH_X   = XW'(STORE_DEPTH);
    localparam logic [XW-1:0] MAXDLY_X  = XW'(STORE_DEPTH - 1);

    // ---------------- config registers ----------------
    // clamping is done on the write, so the datapath sees legal values only
    logic [AW-1:0] delay_reg,  delay_next;
    logic [14:0]   gain_reg,   gain_next;
    logic          ping_reg,   ping_next;
    logic [XW-1:0] wdata_x;

    assign wdata_x = XW'(cfg_wdata);

    always_comb begin
        delay_next = delay_reg;
        gain_next  = gain_reg;
        ping_next  = ping_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH: begin
                    if (wdata_x == '0) begin
                        delay_next = AW'(1);
                    end else if (wdata_x > MAXDLY_X) begin
                        delay_next = LAST_ADDR;
                    end else begin
                        delay_next = wdata_x[AW-1:0];
                    end
                end
                CFG_FEEDBACK_GAIN: begin
                    gain_next = (cfg_wdata > GAIN_CAP) ? GAIN_CAP : cfg_wdata;
                end
                CFG_PING_MODE: begin
                    ping_next = cfg_wdata[0];
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= AW'(1);
            gain_reg  <= '0;
            ping_reg  <= 1'b0;
        end else begin
            delay_reg <= delay_next;
            gain_reg  <= gain_next;
            ping_reg  <= ping_next;
        end
    end

    // ---------------- handshake and pipeline control ----------------
    logic s_fire, s1_fire;
    logic s1_valid_reg;
    logic m_valid_reg;

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    // ---------------- write pointer and fill tracking ----------------
    logic [AW-1:0] w_reg, w_next;
    logic          wrapped_reg;     // every entry has been written at least once

    assign w_next = (w_reg == LAST_ADDR) ? '0 : w_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= '0;
            wrapped_reg <= 1'b0;
        end else if (s_fire) begin
            w_reg <= w_next;
            if (w_reg == LAST_ADDR) begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // read address: (w - delay) mod depth
    logic [XW-1:0] w_x, d_x, raddr_x;
    logic [AW-1:0] raddr;

    assign w_x     = XW'(w_reg);
    assign d_x     = XW'(delay_reg);
    assign raddr_x = (w_x >= d_x) ? (w_x - d_x) : (w_x + DEPTH_X - d_x);
    assign raddr   = raddr_x[AW-1:0];

    // ---------------- delay store: {left, right} per entry ----------------
    logic [31:0] store_mem [STORE_DEPTH];
    logic [31:0] rdata_reg;
    logic [31:0] wr_pair;
    logic [AW-1:0] s1_waddr_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            store_mem[s1_waddr_reg] <= wr_pair;
        end
    end

    // ---------------- stage 1: mix ----------------
    sfd_in_t     s1_in_reg;
    logic        s1_hit_reg;        // read entry is the one written this edge
    logic        s1_ok_reg;         // read entry was written since reset
    logic [31:0] fwd_pair_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_in_reg    <= s_data;
            s1_waddr_reg <= w_reg;
            s1_hit_reg   <= s1_fire && (s1_waddr_reg == raddr);
            s1_ok_reg    <= wrapped_reg || (raddr < w_reg);
            fwd_pair_reg <= wr_pair;
        end
    end

    logic [31:0]        dly_pair;
    logic signed [15:0] dly_l, dly_r;
    logic signed [31:0] prod_l, prod_r;
    logic signed [16:0] fb_l, fb_r;
    logic signed [15:0] out_l, out_r, st_l, st_r;

    always_comb begin
        priority if (s1_hit_reg) begin
            dly_pair = fwd_pair_reg;
        end else if (s1_ok_reg) begin
            dly_pair = rdata_reg;
        end else begin
            dly_pair = '0;
        end
    end

    assign dly_l  = dly_pair[31:16];
    assign dly_r  = dly_pair[15:0];
    // gain is nonnegative: zero-extend into a signed operand
    assign prod_l = $signed({1'b0, gain_reg}) * dly_l;
    assign prod_r = $signed({1'b0, gain_reg}) * dly_r;
    // drop 15 fraction bits, rounding toward minus infinity
    assign fb_l   = prod_l[31:15];
    assign fb_r   = prod_r[31:15];

    assign out_l = mix(s1_in_reg.left_in,  fb_l);
    assign out_r = mix(s1_in_reg.right_in, fb_r);
    // ping-pong crosses only the stored feedback, not the outputs
    assign st_l  = ping_reg ? mix(s1_in_reg.left_in,  fb_r) : out_l;
    assign st_r  = ping_reg ? mix(s1_in_reg.right_in, fb_l) : out_r;
    assign wr_pair = {st_l, st_r};

    // ---------------- output register ----------------
    sfd_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg.left_out  <= out_l;
            m_data_reg.right_out <= out_r;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    `SFD_ASSERT_NEXT(a_wptr_step, s_fire,
        w_reg == (($past(w_reg) == LAST_ADDR) ? '0 : $past(w_reg) + 1'b1),
        "write pointer did not advance by one on an accepted beat")
    `SFD_ASSERT_NOW(a_fwd_only_short, s1_valid_reg && s1_hit_reg,
        delay_reg == AW'(1),
        "forwarding used with a delay other than one sample")
    `SFD_ASSERT_NEXT(a_wrap_sticky, wrapped_reg, wrapped_reg,
        "fill flag cleared without reset")
    `SFD_ASSERT_NOW(a_out_from_stage, $rose(m_valid_reg), $past(s1_fire),
        "result raised without a beat leaving the mix stage")

endmodule

### tb/tb_stereo_feedback_delay_core.sv
// Self-checking testbench for the stereo feedback delay core.
`timescale 1ns / 1ps

module tb_stereo_feedback_delay_core;
    import sfd_pkg::*;

    localparam int DEPTH        = DEFAULT_STORE_DEPTH;
    localparam int RANDOM_BEATS = 1280;
    // Beats sent under the longest delay; every read lands on an entry that
    // has not been written since reset.
    localparam int LONG_DELAY_BEATS = 200;
    // Backstop only: far above the slowest legal run (every beat behind the
    // longest send gap plus the longest result stall).
    localparam int LIMIT_CYCLES = 10_000_000;
    // Spare cycles waited after the last result, before the final queue check.
    localparam int TAIL_CYCLES  = 8;
    // Index 3 is not decoded by the block; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    sfd_in_t           s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    sfd_out_t          m_data;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    stereo_feedback_delay_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the echo engine: both delay lines, the write pointer
    // and the three registers. Only the monitor block touches it.
    // ------------------------------------------------------------------
    logic signed [15:0] echo_left  [DEPTH];
    logic signed [15:0] echo_right [DEPTH];
    int                 echo_wr;
    logic [14:0]        echo_delay;
    logic [14:0]        echo_gain;
    logic               echo_ping;

    sfd_in_t  pending_pairs[$];   // beats waiting for the driver
    sfd_out_t expected_mix[$];    // predicted results, oldest first
    sfd_out_t got_mix, want_mix;
    int       beats_queued  = 0;
    int       beats_checked = 0;
    int       err_count     = 0;
    int       cycle_count   = 0;
    logic     s_beat_taken  = 1'b0;
    int       send_gap = 0, send_quiet = 0;
    int       recv_stall = 0, recv_quiet = 0;

    function automatic logic signed [15:0] clip_q15(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // One sample pair through the echo: read at wr - delay, mix, write back.
    function automatic sfd_out_t predict_pair(input sfd_in_t pair);
        int       lag, gain, rd, dl, dr, fb_l, fb_r, in_l, in_r;
        sfd_out_t res;
        lag = echo_delay;
        if (lag < 1) lag = 1;               // zero delay behaves as one
        if (lag > DEPTH - 1) lag = DEPTH - 1;
        gain = echo_gain;
        if (gain > GAIN_CAP) gain = GAIN_CAP;
        rd   = (echo_wr + DEPTH - lag) % DEPTH;
        dl   = echo_left[rd];
        dr   = echo_right[rd];
        // Arithmetic shift on a signed product rounds toward minus infinity.
        fb_l = (gain * dl) >>> 15;
        fb_r = (gain * dr) >>> 15;
        in_l = pair.left_in;
        in_r = pair.right_in;
        res.left_out  = clip_q15(in_l + fb_l);
        res.right_out = clip_q15(in_r + fb_r);
        if (echo_ping) begin
            // Ping-pong: feedback terms cross over, only in what is stored.
            echo_left[echo_wr]  = clip_q15(in_l + fb_r);
            echo_right[echo_wr] = clip_q15(in_r + fb_l);
        end else begin
            echo_left[echo_wr]  = res.left_out;
            echo_right[echo_wr] = res.right_out;
        end
        echo_wr = (echo_wr + 1) % DEPTH;
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_DELAY_LENGTH:  echo_delay = val;
            CFG_FEEDBACK_GAIN: echo_gain  = val;
            CFG_PING_MODE:     echo_ping  = val[0];
            default: ;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Idle lengths: mostly none or short, a few long, and now and then a
    // stretch of back-to-back cycles with no idling at all.
    function automatic int draw_idle(inout int quiet_left);
        int pick;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            quiet_left = $urandom_range(30, 120);
            return 0;
        end
        if (pick < 62) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender: presents the next pending pair once the previous beat went
    // through, with a random gap in between. Valid holds until accepted.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_beat_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_data   <= pending_pairs.pop_front();
                s_valid  <= 1'b1;
                send_gap <= draw_idle(send_quiet);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready for one cycle, then a random stall that may be zero.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
            recv_stall <= draw_idle(recv_quiet);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats against the oldest prediction, predicts
    // each accepted input beat, and mirrors register writes.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                echo_left[i]  = '0;
                echo_right[i] = '0;
            end
            echo_wr      = 0;
            echo_delay   = 15'd1;
            echo_gain    = '0;
            echo_ping    = 1'b0;
            s_beat_taken <= 1'b0;
        end else begin
            s_beat_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                got_mix = m_data;
                if (expected_mix.size() == 0) begin
                    report_error($sformatf("result beat (%0d, %0d) with nothing expected",
                                           got_mix.left_out, got_mix.right_out));
                end else begin
                    want_mix = expected_mix.pop_front();
                    if (got_mix.left_out !== want_mix.left_out)
                        report_error($sformatf("beat %0d left_out got %0d want %0d",
                                               beats_checked, got_mix.left_out,
                                               want_mix.left_out));
                    if (got_mix.right_out !== want_mix.right_out)
                        report_error($sformatf("beat %0d right_out got %0d want %0d",
                                               beats_checked, got_mix.right_out,
                                               want_mix.right_out));
                    beats_checked++;
                end
            end
            if (s_valid && s_ready)
                expected_mix.push_back(predict_pair(s_data));
            if (cfg_wr_en)
                apply_reg_write(cfg_index, cfg_wdata);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Block until every queued beat has come back, then a little slack.
    task automatic wait_results();
        while (beats_checked != beats_queued) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic push_pair(input int l, input int r);
        sfd_in_t p;
        p.left_in  = l[15:0];
        p.right_in = r[15:0];
        pending_pairs.push_back(p);
        beats_queued++;
    endtask

    // Full-range noise, rail values, or small signals near zero.
    function automatic int rand_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) return $signed(16'($urandom()));
        if (pick < 15) begin
            case ($urandom_range(0, 4))
                0: return 32767;
                1: return -32768;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
        end
        return $urandom_range(0, 511) - 256;
    endfunction

    // Optionally hold the sender halfway until the pipe has fully drained.
    task automatic run_pairs(input int n, input bit pause_mid);
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) wait_results();
            push_pair(rand_sample(), rand_sample());
        end
    endtask

    task automatic configure_random();
        logic [14:0] lag, gain;
        case ($urandom_range(0, 9))
            0:       lag = 15'd0;
            1:       lag = 15'd1;
            2:       lag = 15'h7fff;
            3:       lag = 15'($urandom_range(1, DEPTH - 1));
            default: lag = 15'($urandom_range(1, 48));
        endcase
        case ($urandom_range(0, 7))
            0:       gain = '0;
            1:       gain = GAIN_CAP;
            2:       gain = 15'h7fff;
            3:       gain = 15'($urandom_range(GAIN_CAP, 32767));
            default: gain = 15'($urandom());
        endcase
        write_reg(CFG_DELAY_LENGTH, lag);
        write_reg(CFG_FEEDBACK_GAIN, gain);
        // Upper bits are junk; only bit 0 selects ping-pong.
        write_reg(CFG_PING_MODE, 15'($urandom()));
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED_IDX, 15'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int left_to_send, n;
        bit first_phase;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset config: delay 1, no feedback, so results equal inputs.
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(0, 0);
        push_pair(-1, 1);
        push_pair(1, -1);
        wait_results();

        // Delay 0 behaves as 1, gain above the cap clamps, ping-pong on,
        // and a write to the undecoded index changes nothing.
        write_reg(CFG_DELAY_LENGTH, 15'd0);
        write_reg(CFG_FEEDBACK_GAIN, 15'h7fff);
        write_reg(CFG_PING_MODE, 15'd1);
        write_reg(CFG_UNUSED_IDX, 15'h7fff);
        push_pair(32767, 32767);      // positive rail: sum saturates high
        push_pair(32767, 32767);
        push_pair(-32768, -32768);    // negative rail: sum saturates low
        push_pair(-32768, -32768);
        push_pair(16384, -16384);
        push_pair(0, 0);
        wait_results();

        // Gain exactly at the cap, delay 2, ping bit cleared with upper
        // bits set (they must be dropped).
        write_reg(CFG_DELAY_LENGTH, 15'd2);
        write_reg(CFG_FEEDBACK_GAIN, GAIN_CAP);
        write_reg(CFG_PING_MODE, 15'h7ffe);
        push_pair(32767, -32768);
        push_pair(-32768, 32767);
        push_pair(100, -100);
        push_pair(0, 0);
        push_pair(0, 0);
        push_pair(-1, -1);
        wait_results();

        // Longest delay: reads land on entries not written since reset,
        // which must come back as zero.
        write_reg(CFG_DELAY_LENGTH, 15'h7fff);
        write_reg(CFG_FEEDBACK_GAIN, 15'($urandom_range(16384, 32767)));
        write_reg(CFG_PING_MODE, 15'd1);
        run_pairs(LONG_DELAY_BEATS, 1'b0);
        wait_results();

        // Random phases, each under its own register setting.
        left_to_send = RANDOM_BEATS;
        first_phase  = 1'b1;
        while (left_to_send > 0) begin
            configure_random();
            n = $urandom_range(40, 160);
            if (n > left_to_send) n = left_to_send;
            run_pairs(n, first_phase);
            first_phase = 1'b0;
            left_to_send -= n;
            wait_results();
        end

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_mix.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                                   expected_mix.size()));
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
